FILE: hdl/pairwise_gravity_force_assert.svh
// assertion macros used by the top-level rtl file
`ifndef PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`define PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked by clk, off during reset
`define PGF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pairwise_gravity_force: assertion failed");
// next-cycle implication, clocked by clk, off during reset
`define PGF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pairwise_gravity_force: assertion failed");
`else
`define PGF_ASSERT_IMP(label, ante, cons)
`define PGF_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hdl/pgf_pkg.sv
// types and constants of the pairwise gravity force block
package pgf_pkg;

  localparam int GAIN_BITS  = 32;
  localparam int MASS_BITS  = 32;
  localparam int GAIN_SHIFT = 8;
  localparam int CHUNK_BITS = 32;
  localparam int QUOT_BITS  = 48;
  localparam int OUT_BITS   = 48;

  typedef logic [GAIN_BITS-1:0]       gain_t;
  typedef logic [MASS_BITS-1:0]       mass_t;
  typedef logic signed [OUT_BITS-1:0] force_t;

  localparam gain_t  GAIN_RESET = 32'd16777216;
  localparam force_t FORCE_MAX  = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam force_t FORCE_MIN  = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

FILE: hdl/pgf_mul.sv
// two-stage unsigned multiplier built from 32x32 partial products
module pgf_mul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int CW  = pgf_pkg::CHUNK_BITS;
  localparam int NA  = (A_W + CW - 1) / CW;
  localparam int NB  = (B_W + CW - 1) / CW;
  localparam int SUW = (NA + NB) * CW;

  logic [NA*CW-1:0]   a_pad;
  logic [NB*CW-1:0]   b_pad;
  logic [2*CW-1:0]    pp_r [NA*NB];
  logic [SUW-1:0]     acc;
  logic [A_W+B_W-1:0] p_r;

  assign a_pad = (NA*CW)'(a);
  assign b_pad = (NB*CW)'(b);

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SUW'(pp_r[i*NB+j]) << (CW*(i+j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[A_W+B_W-1:0];
    end
  end

  assign p = p_r;

endmodule

FILE: hdl/pgf_div.sv
// pipelined restoring divider: quotient bits one per stage plus overflow check
module pgf_div #(
  parameter int NUM_W = 137,
  parameter int DEN_W = 99
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [NUM_W-1:0]               num,
  input  logic [DEN_W-1:0]               den,
  output logic [pgf_pkg::QUOT_BITS-1:0]  quot,
  output logic                           ovf
);

  localparam int QB   = pgf_pkg::QUOT_BITS;
  localparam int CMPW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem_r [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic [QB-1:0]    lo_r  [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             ovf_r [QB+1];

  assign num_sh = num >> QB;

  // quotient at or above 2^48 is flagged here; the steps below then need no guard
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= CMPW'(num) >= (CMPW'(den) << QB);
      rem_r[0] <= num_sh[DEN_W-1:0];
      den_r[0] <= den;
      lo_r[0]  <= num[QB-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;

    assign t    = {rem_r[k-1], lo_r[k-1][QB-1]};
    assign diff = t - {1'b0, den_r[k-1]};
    assign ge   = t >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        den_r[k] <= den_r[k-1];
        lo_r[k]  <= lo_r[k-1] << 1;
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quot = q_r[QB];
  assign ovf  = ovf_r[QB];

endmodule

FILE: hdl/pairwise_gravity_force.sv
// top level of the pairwise gravitational force pipeline
// depth: the pipeline depth is set by the root and divider stages
// throughput: one transaction per cycle, every stage advances whenever the output is free
// reset: rst_n synchronous active low, clears all valid bits and loads gravity_gain with 1.0
// config: cfg_ready is always high; write gravity_gain only while the pipeline is empty
module pairwise_gravity_force #(
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  pgf_pkg::gain_t                      cfg_gravity_gain,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [POSITION_BITS-1:0]     in_first_x,
  input  logic signed [POSITION_BITS-1:0]     in_first_y,
  input  logic signed [POSITION_BITS-1:0]     in_first_z,
  input  logic signed [POSITION_BITS-1:0]     in_second_x,
  input  logic signed [POSITION_BITS-1:0]     in_second_y,
  input  logic signed [POSITION_BITS-1:0]     in_second_z,
  input  pgf_pkg::mass_t                      in_first_mass,
  input  pgf_pkg::mass_t                      in_second_mass,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output pgf_pkg::force_t                     out_force_along_x,
  output pgf_pkg::force_t                     out_force_along_y,
  output pgf_pkg::force_t                     out_force_along_z,
  output logic                                out_clipped
);

  `include "pairwise_gravity_force_assert.svh"

  localparam int P        = POSITION_BITS;
  localparam int MW       = P + 1;                 // |difference|
  localparam int R2W      = 2*P + 2;               // sum of squares
  localparam int NS       = P + 1;                 // root bits, one stage each
  localparam int DW       = R2W + NS;              // r^2 * r
  localparam int BW       = pgf_pkg::GAIN_BITS + 2*pgf_pkg::MASS_BITS + pgf_pkg::GAIN_SHIFT;
  localparam int NW       = BW + MW;               // numerator
  localparam int QB       = pgf_pkg::QUOT_BITS;
  localparam int LAT      = NS + 56;               // total register stages
  localparam int NEG_LEN  = NS + 55;               // sign bits from stage 1 to the divider exit
  localparam int ZERO_LEN = NS + 52;               // zero flag from stage 4 to the divider exit
  localparam int NUM_LEN  = NS - 1;                // numerator wait for the denominator

  // global advance: a stalled result freezes every stage, nothing is lost or repeated
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // configuration register
  pgf_pkg::gain_t gain_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= pgf_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_gravity_gain;
    end
  end

  // valid bits travel alongside the data
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: per-axis difference, split into sign and magnitude
  logic [P-1:0]  fp [3];
  logic [P-1:0]  sp [3];
  logic [MW-1:0] mag_w [3];
  logic [2:0]    neg_w;

  assign fp[0] = in_first_x;
  assign fp[1] = in_first_y;
  assign fp[2] = in_first_z;
  assign sp[0] = in_second_x;
  assign sp[1] = in_second_y;
  assign sp[2] = in_second_z;

  for (genvar k = 0; k < 3; k++) begin : g_diff
    logic [MW-1:0] d;
    assign d        = {fp[k][P-1], fp[k]} - {sp[k][P-1], sp[k]};
    assign neg_w[k] = d[MW-1];
    assign mag_w[k] = d[MW-1] ? (~d + MW'(1)) : d;
  end

  logic [MW-1:0]  mag_p_r [5][3];   // index 0 is stage 1, index 4 is stage 5
  pgf_pkg::mass_t m1_r;
  pgf_pkg::mass_t m2_p_r [3];       // index 0 is stage 1
  logic [2:0]     neg_p_r [NEG_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_p_r[0] <= mag_w;
      for (int i = 1; i < 5; i++) begin
        mag_p_r[i] <= mag_p_r[i-1];
      end
      m1_r      <= in_first_mass;
      m2_p_r[0] <= in_second_mass;
      for (int i = 1; i < 3; i++) begin
        m2_p_r[i] <= m2_p_r[i-1];
      end
      neg_p_r[0] <= neg_w;
      for (int i = 1; i < NEG_LEN; i++) begin
        neg_p_r[i] <= neg_p_r[i-1];
      end
    end
  end

  // stages 2-3: squares and gain * m1
  logic [R2W-1:0] sq [3];
  logic [63:0]    gm1;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    pgf_mul #(.A_W(MW), .B_W(MW)) u_sq (
      .clk(clk), .en(en), .a(mag_p_r[0][k]), .b(mag_p_r[0][k]), .p(sq[k])
    );
  end

  pgf_mul #(.A_W(pgf_pkg::GAIN_BITS), .B_W(pgf_pkg::MASS_BITS)) u_gm1 (
    .clk(clk), .en(en), .a(gain_r), .b(m1_r), .p(gm1)
  );

  // stage 4: r^2 and the coincident-body flag
  logic [R2W-1:0] r2_sum;
  logic [R2W-1:0] r2_r;
  logic           zero_p_r [ZERO_LEN];

  assign r2_sum = sq[0] + sq[1] + sq[2];

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r        <= r2_sum;
      zero_p_r[0] <= (r2_sum == '0);
      for (int i = 1; i < ZERO_LEN; i++) begin
        zero_p_r[i] <= zero_p_r[i-1];
      end
    end
  end

  // stages 4-5: gain * m1 * m2, then stages 6-7: times |d| per axis
  logic [BW-pgf_pkg::GAIN_SHIFT-1:0] base;
  logic [NW-1:0]                     num_w [3];
  logic [NW-1:0]                     num_p_r [NUM_LEN][3];

  pgf_mul #(.A_W(64), .B_W(pgf_pkg::MASS_BITS)) u_base (
    .clk(clk), .en(en), .a(gm1), .b(m2_p_r[2]), .p(base)
  );

  for (genvar k = 0; k < 3; k++) begin : g_num
    pgf_mul #(.A_W(BW), .B_W(MW)) u_num (
      .clk(clk), .en(en), .a({base, {pgf_pkg::GAIN_SHIFT{1'b0}}}), .b(mag_p_r[4][k]),
      .p(num_w[k])
    );
  end

  // numerator waits while the root settles
  always_ff @(posedge clk) begin
    if (en) begin
      num_p_r[0] <= num_w;
      for (int i = 1; i < NUM_LEN; i++) begin
        num_p_r[i] <= num_p_r[i-1];
      end
    end
  end

  // integer square root, one result bit per stage from the top down
  logic [R2W-1:0] rem_s_r  [NS];
  logic [NS-1:0]  root_s_r [NS];
  logic [R2W-1:0] r2_s_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int B = NS - 1 - k;
    logic [R2W-1:0] rem_in;
    logic [NS-1:0]  root_in;
    logic [R2W-1:0] r2_in;
    logic [R2W-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = r2_r;
      assign root_in = '0;
      assign r2_in   = r2_r;
    end else begin : g_next
      assign rem_in  = rem_s_r[k-1];
      assign root_in = root_s_r[k-1];
      assign r2_in   = r2_s_r[k-1];
    end

    // (s + 2^b)^2 - s^2 = s*2^(b+1) + 2^(2b)
    assign trial = (R2W'(root_in) << (B + 1)) | (R2W'(1) << (2*B));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s_r[k]  <= ge ? rem_in - trial : rem_in;
        root_s_r[k] <= ge ? (root_in | (NS'(1) << B)) : root_in;
        r2_s_r[k]   <= r2_in;
      end
    end
  end

  // denominator r^2 * r
  logic [DW-1:0] den;
  pgf_mul #(.A_W(R2W), .B_W(NS)) u_den (
    .clk(clk), .en(en), .a(r2_s_r[NS-1]), .b(root_s_r[NS-1]), .p(den)
  );

  // one divider per axis
  logic [QB-1:0] quot [3];
  logic [2:0]    ovf;

  for (genvar k = 0; k < 3; k++) begin : g_div
    pgf_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clk(clk), .en(en), .num(num_p_r[NUM_LEN-1][k]), .den(den),
      .quot(quot[k]), .ovf(ovf[k])
    );
  end

  // saturate, apply sign, zero out coincident bodies
  pgf_pkg::force_t force_w [3];
  logic [2:0]      clip_w;
  logic [2:0]      neg_f;
  logic            zero_f;

  assign neg_f  = neg_p_r[NEG_LEN-1];
  assign zero_f = zero_p_r[ZERO_LEN-1];

  for (genvar k = 0; k < 3; k++) begin : g_sat
    logic over;
    // magnitude limit is 2^47 for negative results, 2^47-1 for positive
    assign over = ovf[k] || (quot[k][QB-1] && (!neg_f[k] || (quot[k][QB-2:0] != '0)));
    assign clip_w[k] = over && !zero_f;
    always_comb begin
      if (zero_f) begin
        force_w[k] = '0;
      end else if (over) begin
        force_w[k] = neg_f[k] ? pgf_pkg::FORCE_MIN : pgf_pkg::FORCE_MAX;
      end else begin
        force_w[k] = neg_f[k] ? pgf_pkg::force_t'(-quot[k]) : pgf_pkg::force_t'(quot[k]);
      end
    end
  end

  // output register
  pgf_pkg::force_t fx_r;
  pgf_pkg::force_t fy_r;
  pgf_pkg::force_t fz_r;
  logic            clip_r;
  logic            zero_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r       <= force_w[0];
      fy_r       <= force_w[1];
      fz_r       <= force_w[2];
      clip_r     <= |clip_w;
      zero_out_r <= zero_f;
    end
  end

  assign out_valid         = vld_r[LAT-1];
  assign out_force_along_x = fx_r;
  assign out_force_along_y = fy_r;
  assign out_force_along_z = fz_r;
  assign out_clipped       = clip_r;

  // an accepted transaction enters the first stage
  `PGF_ASSERT_NXT(a_enter, in_valid && !in_stall, vld_r[0])
  // a stalled result freezes the whole valid chain
  `PGF_ASSERT_NXT(a_freeze, out_valid && out_stall, $stable(vld_r))
  // coincident bodies give zero force and no clip
  `PGF_ASSERT_IMP(a_zero, out_valid && zero_out_r,
                  !out_clipped && out_force_along_x == '0 && out_force_along_y == '0 &&
                  out_force_along_z == '0)
  // a clip leaves at least one component at a rail
  `PGF_ASSERT_IMP(a_clip_rail, out_valid && out_clipped,
                  out_force_along_x == pgf_pkg::FORCE_MAX ||
                  out_force_along_x == pgf_pkg::FORCE_MIN ||
                  out_force_along_y == pgf_pkg::FORCE_MAX ||
                  out_force_along_y == pgf_pkg::FORCE_MIN ||
                  out_force_along_z == pgf_pkg::FORCE_MAX ||
                  out_force_along_z == pgf_pkg::FORCE_MIN)

endmodule

FILE: tb/tb_pairwise_gravity_force.sv
// self-checking testbench for the pairwise gravitational force pipeline
module tb_pairwise_gravity_force;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS = 32;
  localparam int LATENCY = POS_BITS + 56;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1450;

  typedef struct {
    pgf_pkg::force_t fx;
    pgf_pkg::force_t fy;
    pgf_pkg::force_t fz;
    logic            clip;
  } force_result_t;

  typedef logic signed [POS_BITS-1:0] pos_t;

  // expected forces in acceptance order, plus the predictor that fills them
  class force_scoreboard;
    force_result_t pending_forces[$];
    pgf_pkg::gain_t gain;
    int mismatches;
    int checked;
    int clipped_seen;
    int coincident_seen;

    function void set_gain(pgf_pkg::gain_t g);
      gain = g;
    endfunction

    // exact integer square root, floor, of a value under 2^106
    function automatic logic [55:0] isqrt(logic [107:0] v);
      logic [55:0] s;
      logic [55:0] c;
      s = '0;
      for (int b = 53; b >= 0; b--) begin
        c = s | (56'd1 << b);
        if (c * c <= v) s = c;
      end
      return s;
    endfunction

    function void note_pair(pos_t p1[3], pos_t p2[3], pgf_pkg::mass_t m1,
                            pgf_pkg::mass_t m2);
      logic signed [POS_BITS:0] d[3];
      logic [POS_BITS:0] mag[3];
      logic [107:0] r2;
      logic [55:0] s;
      logic [191:0] base;
      logic [191:0] den;
      logic [191:0] q;
      logic [47:0] lim;
      logic [47:0] qv;
      pgf_pkg::force_t f[3];
      force_result_t res;
      r2 = '0;
      res.clip = 1'b0;
      for (int k = 0; k < 3; k++) begin
        d[k] = $signed({p1[k][POS_BITS-1], p1[k]}) - $signed({p2[k][POS_BITS-1], p2[k]});
        mag[k] = d[k] < 0 ? -d[k] : d[k];
        r2 += 108'(mag[k]) * 108'(mag[k]);
      end
      if (r2 == 0) begin
        coincident_seen++;
        f[0] = '0; f[1] = '0; f[2] = '0;
      end else begin
        s = isqrt(r2);
        den = 192'(r2) * 192'(s);
        base = (192'(gain) << 8) * 192'(m1) * 192'(m2);
        for (int k = 0; k < 3; k++) begin
          q = (base * 192'(mag[k])) / den;
          lim = d[k] < 0 ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
          if (q > 192'(lim)) begin
            qv = lim;
            res.clip = 1'b1;
          end else begin
            qv = q[47:0];
          end
          f[k] = d[k] < 0 ? -qv : qv;
        end
      end
      res.fx = f[0]; res.fy = f[1]; res.fz = f[2];
      if (res.clip) clipped_seen++;
      pending_forces.push_back(res);
    endfunction

    function void check_result(force_result_t got);
      force_result_t want;
      checked++;
      if (pending_forces.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatches++;
        return;
      end
      want = pending_forces.pop_front();
      if (got.fx !== want.fx) begin
        $error("force_along_x expected %0d actual %0d", want.fx, got.fx);
        mismatches++;
      end
      if (got.fy !== want.fy) begin
        $error("force_along_y expected %0d actual %0d", want.fy, got.fy);
        mismatches++;
      end
      if (got.fz !== want.fz) begin
        $error("force_along_z expected %0d actual %0d", want.fz, got.fz);
        mismatches++;
      end
      if (got.clip !== want.clip) begin
        $error("clipped expected %0b actual %0b", want.clip, got.clip);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  pgf_pkg::gain_t cfg_gravity_gain;
  logic in_valid;
  logic in_stall;
  pos_t in_first_x, in_first_y, in_first_z;
  pos_t in_second_x, in_second_y, in_second_z;
  pgf_pkg::mass_t in_first_mass, in_second_mass;
  logic out_valid;
  logic out_stall;
  pgf_pkg::force_t out_force_along_x, out_force_along_y, out_force_along_z;
  logic out_clipped;

  force_scoreboard board;
  int cycle_count;
  int sent_items;
  int gain_writes;
  bit stall_free_run;

  pairwise_gravity_force #(.POSITION_BITS(POS_BITS)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_gravity_gain  (cfg_gravity_gain),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_x        (in_first_x),
    .in_first_y        (in_first_y),
    .in_first_z        (in_first_z),
    .in_second_x       (in_second_x),
    .in_second_y       (in_second_y),
    .in_second_z       (in_second_z),
    .in_first_mass     (in_first_mass),
    .in_second_mass    (in_second_mass),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_force_along_x (out_force_along_x),
    .out_force_along_y (out_force_along_y),
    .out_force_along_z (out_force_along_z),
    .out_clipped       (out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check each transaction accepted at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_force_along_x, out_force_along_y, out_force_along_z,
                           out_clipped});
  end

  // receiver stall pattern: phases of free flow, light and heavy stalling
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = stall_free_run ? 0 : $urandom_range(0, 2);
      span = $urandom_range(5, 120);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // one input transaction; valid stays up across back-to-back items
  task automatic push_pair(pos_t p1[3], pos_t p2[3], pgf_pkg::mass_t m1,
                           pgf_pkg::mass_t m2);
    in_valid <= 1'b1;
    in_first_x <= p1[0]; in_first_y <= p1[1]; in_first_z <= p1[2];
    in_second_x <= p2[0]; in_second_y <= p2[1]; in_second_z <= p2[2];
    in_first_mass <= m1;
    in_second_mass <= m2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(p1, p2, m1, m2);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait for the pipeline to drain before a gain write
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (board.pending_forces.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_gain(pgf_pkg::gain_t g);
    cfg_valid <= 1'b1;
    cfg_gravity_gain <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_gain(g);
    gain_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random pair; mostly moderate separations so forces land in range
  task automatic random_pair();
    pos_t p1[3], p2[3];
    pgf_pkg::mass_t m1, m2;
    int shape;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      p1[k] = $urandom;
      case (shape)
        0: p2[k] = $urandom;
        1: p2[k] = p1[k];
        2: p2[k] = p1[k] + $signed($urandom_range(0, 15)) - 8;
        default: p2[k] = p1[k] + ($signed($urandom) >>> $urandom_range(4, 24));
      endcase
    end
    if (shape == 1 && $urandom_range(0, 1)) p2[$urandom_range(0, 2)] ^= 32'h1;
    m1 = $urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(8, 24);
    m2 = $urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(8, 24);
    push_pair(p1, p2, m1, m2);
  endtask

  initial begin
    pos_t zero3[3];
    pos_t maxp[3], minp[3], unit_x[3], mixed[3];
    pgf_pkg::gain_t gain_set[5];
    int burst;
    board = new();
    board.set_gain(pgf_pkg::GAIN_RESET);
    stall_free_run = 1'b0;
    cycle_count = 0;
    sent_items = 0;
    gain_writes = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_gravity_gain = '0;
    in_valid = 1'b0;
    {in_first_x, in_first_y, in_first_z} = '0;
    {in_second_x, in_second_y, in_second_z} = '0;
    in_first_mass = '0;
    in_second_mass = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    zero3 = '{0, 0, 0};
    maxp = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    minp = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    unit_x = '{32'sh10000, 0, 0};
    mixed = '{32'sh7fffffff, 32'sh80000000, 32'sh1};

    // directed: reset gain, extremes, coincident bodies, overflow
    push_pair(zero3, zero3, 32'h10000, 32'h10000);        // coincident
    push_pair(maxp, maxp, 32'hffffffff, 32'hffffffff);    // coincident at extreme
    push_pair(unit_x, zero3, 32'h10000, 32'h10000);       // unit force
    push_pair(zero3, unit_x, 32'h10000, 32'h10000);       // negative direction
    push_pair(maxp, minp, 32'hffffffff, 32'hffffffff);    // widest span
    push_pair(minp, maxp, 32'hffffffff, 32'hffffffff);
    push_pair(mixed, zero3, 32'h1, 32'h1);
    push_pair('{1, 0, 0}, zero3, 32'hffffffff, 32'hffffffff);  // positive saturation
    push_pair(zero3, '{1, 1, 0}, 32'hffffffff, 32'hffffffff);  // negative saturation
    push_pair(unit_x, zero3, 32'h0, 32'hffffffff);        // zero mass
    push_pair('{3, 4, 0}, zero3, 32'h10000, 32'h10000);
    push_pair('{1, 1, 1}, '{32'sh80000000, 0, 32'sh7fffffff}, 32'haaaaaaaa, 32'h55555555);
    idle_sender(3);
    drain_pipeline();

    // gain settings including both extremes
    gain_set = '{32'h0, 32'hffffffff, 32'h1, 32'h00400000, pgf_pkg::GAIN_RESET};
    foreach (gain_set[g]) begin
      write_gain(gain_set[g]);
      push_pair(unit_x, zero3, 32'h10000, 32'h10000);
      push_pair('{1, 0, 0}, zero3, 32'hffffffff, 32'hffffffff);
      push_pair(mixed, zero3, 32'h12345678, 32'h9abcdef0);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        if (i == 40 && g == 2) begin
          // pause until everything in flight has returned
          in_valid <= 1'b0;
          while (board.pending_forces.size() != 0) @(negedge clk);
        end
        stall_free_run = (i > 200 && i < 240);
        random_pair();
        if ($urandom_range(0, 15) == 0 && !stall_free_run) begin
          burst = $urandom_range(1, 12);
          idle_sender(burst);
        end
      end
      drain_pipeline();
    end

    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d pairs over %0d gain writes, checked %0d results",
             sent_items, gain_writes, board.checked);
    $display("coincident pairs %0d, clipped results %0d",
             board.coincident_seen, board.clipped_seen);
    if (board.mismatches == 0 && board.pending_forces.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pgf_pkg.sv
hdl/pgf_mul.sv
hdl/pgf_div.sv
hdl/pairwise_gravity_force.sv
tb/tb_pairwise_gravity_force.sv
